// File: rtl/core/ird_pkg.sv
package ird_pkg;

  localparam int ValueWidth      = 32;
  localparam int CharWidth       = 8;
  localparam int RadixWidth      = 5;
  localparam int DigitWidth      = 4;
  localparam int NumDigitChars   = 16;
  localparam int MaxDigits       = 32;
  localparam int DigitCntWidth   = 6;
  localparam int CfgIdxWidth     = 2;
  localparam int CfgDataWidth    = 64;
  localparam int DefaultMaxRadix = 16;
  localparam int RadixLimit      = 16;
  localparam int DivStepsPerCyc  = 8;

  localparam logic [CharWidth-1:0] CharMinus   = 8'h2D;
  localparam logic [CharWidth-1:0] CharPlus    = 8'h2B;
  localparam logic [CharWidth-1:0] CharLowest  = 8'd32;
  localparam logic [CharWidth-1:0] CharHighest = 8'd127;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegRadix     = 2'd0,
    RegCharsLow  = 2'd1,
    RegCharsHigh = 2'd2
  } cfg_reg_e;

  typedef logic [NumDigitChars-1:0][CharWidth-1:0] digit_set_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  typedef struct packed {
    logic                  done;
    logic [ValueWidth-1:0] quot;
    logic [DigitWidth-1:0] rem;
  } div_status_t;

endpackage

// File: rtl/core/integer_to_radix_digits_top.sv
// Signed 32-bit integer to text in a configurable radix, sent one character at a time.
// Input channel: value_i with in_valid_i / in_stall_o. Output channel: out_char_o
// and last_o with out_valid_o / out_stall_i; last_o marks the final character.
// Configuration: cfg_index_i selects radix (0), digit chars 0..7 (1) or 8..15 (2);
// a write lands when cfg_valid_i and cfg_ready_o are both high. Write only while
// the block is idle.
// Per item: accept, then the digit set is checked, one digit character
// per cycle; the scan stops early at a bad or repeated character, and a radix out
// of range is rejected without a scan. A bad set drops the item with no output.
// Digits come from one shared divider that retires 8 quotient bits a cycle;
// each quotient is fed back to it as the next dividend. Then one character
// per cycle while the output is not stalled ('-' first for negatives),
// most significant digit first.
// One item is in work at a time; in_stall_o is high from accept until it is
// dropped or its last character is in the output register, so the next item can be
// taken while that character still waits. A stalled output holds its character
// and pauses emission. Reset clears the configuration to zero (radix 0, so every
// item is rejected until configured) and returns to idle with no output pending.
module integer_to_radix_digits_top #(
  parameter int MaxRadix = ird_pkg::DefaultMaxRadix
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ird_pkg::ValueWidth-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ird_pkg::CharWidth-1:0]         out_char_o,
  output logic                                  last_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ird_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [ird_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  localparam int StackWidth = ird_pkg::MaxDigits * ird_pkg::DigitWidth;
  localparam int HalfChars  = ird_pkg::NumDigitChars / 2;

  typedef enum logic [2:0] {
    Idle,
    Check,
    Divide,
    EmitSign,
    EmitDigits
  } state_e;

  state_e                                state_q;
  logic [ird_pkg::RadixWidth-1:0]        radix_q;
  ird_pkg::digit_set_t                   chars_q;
  logic                                  neg_q;
  logic [ird_pkg::ValueWidth-1:0]        mag_q;
  logic [StackWidth-1:0]                 stack_q;
  logic [ird_pkg::DigitCntWidth-1:0]     nd_q;
  logic                                  out_valid_q;
  logic [ird_pkg::CharWidth-1:0]         out_char_q;
  logic                                  out_last_q;

  logic                                  in_fire;
  logic                                  out_free;
  logic                                  chk_start;
  logic                                  div_start;
  logic                                  more_digits;
  logic [ird_pkg::DigitCntWidth-1:0]     nd_next;
  logic [ird_pkg::ValueWidth-1:0]        dividend;
  ird_pkg::chk_status_t                  chk_st;
  ird_pkg::div_status_t                  div_st;

  assign in_stall_o  = (state_q != Idle);
  assign cfg_ready_o = (state_q == Idle);
  assign in_fire     = in_valid_i && (state_q == Idle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign chk_start   = in_fire;
  assign nd_next     = nd_q + ird_pkg::DigitCntWidth'(1);
  assign more_digits = (div_st.quot != '0) &&
                       (nd_next < ird_pkg::DigitCntWidth'(ird_pkg::MaxDigits));
  assign div_start   = ((state_q == Check) && chk_st.done && chk_st.ok) ||
                       ((state_q == Divide) && div_st.done && more_digits);
  assign dividend    = (state_q == Check) ? mag_q : div_st.quot;

  ird_check #(
    .MaxRadix(MaxRadix)
  ) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chk_start),
    .radix_i (radix_q),
    .chars_i (chars_q),
    .status_o(chk_st)
  );

  ird_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (radix_q),
    .status_o  (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
      chars_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ird_pkg::RegRadix:     radix_q <= cfg_data_i[ird_pkg::RadixWidth-1:0];
        ird_pkg::RegCharsLow:  chars_q[HalfChars-1:0] <= cfg_data_i;
        ird_pkg::RegCharsHigh: chars_q[ird_pkg::NumDigitChars-1:HalfChars] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      neg_q       <= 1'b0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        Idle: begin
          if (in_fire) begin
            neg_q   <= value_i[ird_pkg::ValueWidth-1];
            nd_q    <= '0;
            state_q <= Check;
          end
        end
        Check: begin
          if (chk_st.done) begin
            state_q <= chk_st.ok ? Divide : Idle;
          end
        end
        Divide: begin
          if (div_st.done) begin
            nd_q <= nd_next;
            if (!more_digits) begin
              state_q <= neg_q ? EmitSign : EmitDigits;
            end
          end
        end
        EmitSign: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b0;
            state_q     <= EmitDigits;
          end
        end
        EmitDigits: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= (nd_q == ird_pkg::DigitCntWidth'(1));
            nd_q        <= nd_q - ird_pkg::DigitCntWidth'(1);
            if (nd_q == ird_pkg::DigitCntWidth'(1)) begin
              state_q <= Idle;
            end
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // payload: magnitude, digit stack (last digit found is on top), output char
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q <= value_i[ird_pkg::ValueWidth-1] ? (ird_pkg::ValueWidth'(0) - value_i)
                                              : value_i;
    end
    if ((state_q == Divide) && div_st.done) begin
      stack_q <= {stack_q[StackWidth-ird_pkg::DigitWidth-1:0], div_st.rem};
    end else if ((state_q == EmitDigits) && out_free) begin
      stack_q <= {ird_pkg::DigitWidth'(0), stack_q[StackWidth-1:ird_pkg::DigitWidth]};
    end
    if ((state_q == EmitSign) && out_free) begin
      out_char_q <= ird_pkg::CharMinus;
    end else if ((state_q == EmitDigits) && out_free) begin
      out_char_q <= chars_q[stack_q[ird_pkg::DigitWidth-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  a_nd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= ird_pkg::DigitCntWidth'(ird_pkg::MaxDigits)) else $error("digit count overflow");
  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EmitDigits) |-> (nd_q != '0)) else $error("emitting with empty stack");
  a_divide_radix_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Divide) |-> (radix_q >= ird_pkg::RadixWidth'(2)))
    else $error("dividing by an unchecked radix");

endmodule

// File: rtl/core/ird_check.sv
module ird_check #(
  parameter int MaxRadix = ird_pkg::DefaultMaxRadix
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ird_pkg::RadixWidth-1:0]      radix_i,
  input  ird_pkg::digit_set_t                 chars_i,
  output ird_pkg::chk_status_t                status_o
);

  localparam int IdxWidth = $clog2(ird_pkg::NumDigitChars);

  logic                             busy_q;
  logic                             done_q;
  logic                             ok_q;
  logic [IdxWidth-1:0]              idx_q;
  logic [ird_pkg::CharWidth-1:0]    cur_char;
  logic                             bad_char;
  logic                             dup_char;
  logic                             radix_bad;
  logic [IdxWidth-1:0]              last_idx;

  assign radix_bad = (radix_i < ird_pkg::RadixWidth'(2)) ||
                     (radix_i > ird_pkg::RadixWidth'(MaxRadix)) ||
                     (radix_i > ird_pkg::RadixWidth'(ird_pkg::RadixLimit));
  assign last_idx  = IdxWidth'(radix_i - ird_pkg::RadixWidth'(1));
  assign cur_char  = chars_i[idx_q];
  assign bad_char  = (cur_char == ird_pkg::CharMinus) || (cur_char == ird_pkg::CharPlus) ||
                     (cur_char < ird_pkg::CharLowest) || (cur_char > ird_pkg::CharHighest);

  // compare the current character against every later used one
  always_comb begin
    dup_char = 1'b0;
    for (int j = 0; j < ird_pkg::NumDigitChars; j++) begin
      if ((ird_pkg::RadixWidth'(j) > {1'b0, idx_q}) &&
          (ird_pkg::RadixWidth'(j) < radix_i) && (chars_i[j] == cur_char)) begin
        dup_char = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      if (start_i) begin
        idx_q <= '0;
        if (radix_bad) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (bad_char || dup_char) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (idx_q == last_idx) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          ok_q   <= 1'b1;
        end else begin
          idx_q <= idx_q + IdxWidth'(1);
        end
      end
    end
  end

  assign status_o.done = done_q;
  assign status_o.ok   = ok_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && busy_q)) else $error("check done while still busy");
  a_ok_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_q |-> done_q) else $error("ok flag without done");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("check started while busy");

endmodule

// File: rtl/core/ird_div.sv
module ird_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ird_pkg::ValueWidth-1:0]     dividend_i,
  input  logic [ird_pkg::RadixWidth-1:0]     divisor_i,
  output ird_pkg::div_status_t               status_o
);

  localparam int NumCycles = ird_pkg::ValueWidth / ird_pkg::DivStepsPerCyc;
  localparam int CntWidth  = (NumCycles > 1) ? $clog2(NumCycles) : 1;

  logic                              busy_q;
  logic                              done_q;
  logic [CntWidth-1:0]               cnt_q;
  logic [ird_pkg::ValueWidth-1:0]    work_q, work_d;
  logic [ird_pkg::DigitWidth-1:0]    rem_q, rem_d;
  logic [ird_pkg::RadixWidth-1:0]    trial;

  // restoring division, a fixed number of quotient bits per cycle
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int s = 0; s < ird_pkg::DivStepsPerCyc; s++) begin
      trial  = {rem_d, work_d[ird_pkg::ValueWidth-1]};
      work_d = {work_d[ird_pkg::ValueWidth-2:0], 1'b0};
      if (trial >= divisor_i) begin
        trial     = trial - divisor_i;
        work_d[0] = 1'b1;
      end
      rem_d = trial[ird_pkg::DigitWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(NumCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign status_o.done = done_q;
  assign status_o.quot = work_q;
  assign status_o.rem  = rem_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && busy_q)) else $error("divider done while busy");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && divisor_i >= ird_pkg::RadixWidth'(2)) |->
      ({1'b0, rem_q} < divisor_i)) else $error("remainder not below divisor");

endmodule

// File: test/radix_text_checker.sv
`timescale 1ns / 1ps
module radix_text_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [ird_pkg::ValueWidth-1:0]   value_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [ird_pkg::CharWidth-1:0]    out_char_i,
  input  logic                             last_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [ird_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [ird_pkg::CfgDataWidth-1:0] cfg_data_i,
  output int                               mismatch_count_o,
  output int                               chars_pending_o
);

  typedef struct packed {
    logic [ird_pkg::CharWidth-1:0] ch;
    logic                          last;
  } text_char_t;

  text_char_t                     expected_chars[$];
  text_char_t                     want;
  logic [ird_pkg::RadixWidth-1:0] radix_q;
  ird_pkg::digit_set_t            digits_q;

  function automatic logic digit_set_ok();
    int i;
    int j;
    logic [ird_pkg::CharWidth-1:0] c;
    if (radix_q < 2 || radix_q > ird_pkg::DefaultMaxRadix ||
        radix_q > ird_pkg::RadixLimit) return 1'b0;
    for (i = 0; i < radix_q; i++) begin
      c = digits_q[i];
      if (c == ird_pkg::CharMinus || c == ird_pkg::CharPlus ||
          c < ird_pkg::CharLowest || c > ird_pkg::CharHighest) return 1'b0;
      for (j = i + 1; j < radix_q; j++) begin
        if (digits_q[j] == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queues the characters one value turns into; nothing for a rejected digit set.
  function automatic void predict_text(input logic [ird_pkg::ValueWidth-1:0] raw);
    logic [ird_pkg::ValueWidth-1:0] mag;
    logic [ird_pkg::DigitWidth-1:0] digits[ird_pkg::MaxDigits];
    int nd;
    if (!digit_set_ok()) return;
    // unsigned magnitude, so the most negative value needs no special case
    mag = raw[ird_pkg::ValueWidth-1] ? -raw : raw;
    nd = 0;
    do begin
      digits[nd] = ird_pkg::DigitWidth'(mag % radix_q);
      mag = mag / radix_q;
      nd++;
    end while (mag != 0 && nd < ird_pkg::MaxDigits);
    if (raw[ird_pkg::ValueWidth-1]) expected_chars.push_back('{ird_pkg::CharMinus, 1'b0});
    while (nd > 0) begin
      nd--;
      expected_chars.push_back('{digits_q[digits[nd]], nd == 0});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = '0;
      digits_q = '0;
      expected_chars.delete();
      mismatch_count_o = 0;
      chars_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ird_pkg::RegRadix:     radix_q = cfg_data_i[ird_pkg::RadixWidth-1:0];
          ird_pkg::RegCharsLow:  digits_q[7:0] = cfg_data_i;
          ird_pkg::RegCharsHigh: digits_q[15:8] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_text(value_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected item: out_char %h last %b", out_char_i, last_i);
          mismatch_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_i !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char_i);
            mismatch_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_i);
            mismatch_count_o++;
          end
        end
      end
      chars_pending_o = expected_chars.size();
    end
  end

endmodule

// File: test/tb_integer_to_radix_digits_top.sv
`timescale 1ns / 1ps
module tb_integer_to_radix_digits_top;

  localparam int DrainCycles   = 200;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 3000;
  localparam int RandomPhases  = 9;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallRuns
  } stall_mode_e;

  logic                                  clk_i       = 1'b0;
  logic                                  rst_ni      = 1'b0;
  logic                                  in_valid_i  = 1'b0;
  logic                                  in_stall_o;
  logic signed [ird_pkg::ValueWidth-1:0] value_i     = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic [ird_pkg::CharWidth-1:0]         out_char_o;
  logic                                  last_o;
  logic                                  cfg_valid_i = 1'b0;
  logic                                  cfg_ready_o;
  logic [ird_pkg::CfgIdxWidth-1:0]       cfg_index_i = ird_pkg::RegRadix;
  logic [ird_pkg::CfgDataWidth-1:0]      cfg_data_i  = '0;

  int mismatch_count;
  int chars_pending;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_off_req = 1'b0;

  integer_to_radix_digits_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  radix_text_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_i       (out_char_o),
    .last_i           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .chars_pending_o  (chars_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side back-pressure: random modes, plus one long hold-off on request.
  initial begin
    stall_mode_e mode;
    int left;
    mode = StallNone;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= left[2];
        endcase
      end
    end
  end

  // Offers one item and returns at the edge that takes it; valid stays high
  // so a burst can continue without a bubble.
  task automatic send_value(input logic [ird_pkg::ValueWidth-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    burst_left--;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (chars_pending != 0);
  endtask

  // A rejected item leaves nothing to wait on, so give the block its full latency.
  task automatic finish_phase();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [ird_pkg::RadixWidth-1:0] rdx,
                              input ird_pkg::digit_set_t set);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ird_pkg::RegRadix;
    cfg_data_i <= ird_pkg::CfgDataWidth'(rdx);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= ird_pkg::RegCharsLow;
    cfg_data_i <= set[7:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= ird_pkg::RegCharsHigh;
    cfg_data_i <= set[15:8];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic convert_once(input logic [ird_pkg::RadixWidth-1:0] rdx,
                              input ird_pkg::digit_set_t set,
                              input logic [ird_pkg::ValueWidth-1:0] v);
    write_config(rdx, set);
    send_value(v);
    finish_phase();
  endtask

  function automatic ird_pkg::digit_set_t hex_digit_set();
    ird_pkg::digit_set_t set;
    int k;
    for (k = 0; k < ird_pkg::NumDigitChars; k++) begin
      set[k] = (k < 10) ? 8'(8'h30 + k) : 8'(8'h37 + k);
    end
    return set;
  endfunction

  // Distinct legal digits (32..127, no sign characters) for the used values, anything at all in the rest.
  function automatic ird_pkg::digit_set_t random_digit_set(input int n);
    ird_pkg::digit_set_t set;
    logic [255:0] used;
    logic [ird_pkg::CharWidth-1:0] c;
    int k;
    used = '0;
    for (k = 0; k < ird_pkg::NumDigitChars; k++) set[k] = ird_pkg::CharWidth'($urandom);
    for (k = 0; k < n; k++) begin
      do c = ird_pkg::CharWidth'($urandom_range(32, 127));
      while (c == ird_pkg::CharPlus || c == ird_pkg::CharMinus || used[c]);
      used[c] = 1'b1;
      set[k] = c;
    end
    return set;
  endfunction

  function automatic void spoil_digit_set(inout logic [ird_pkg::RadixWidth-1:0] rdx,
                                          inout ird_pkg::digit_set_t set);
    int j;
    case ($urandom_range(0, 3))
      0: begin
        j = $urandom_range(1, rdx - 1);
        set[j] = set[$urandom_range(0, j - 1)];
      end
      1: begin
        j = $urandom_range(0, rdx - 1);
        case ($urandom_range(0, 3))
          0:       set[j] = ird_pkg::CharMinus;
          1:       set[j] = ird_pkg::CharPlus;
          2:       set[j] = ird_pkg::CharWidth'($urandom_range(0, 31));
          default: set[j] = ird_pkg::CharWidth'($urandom_range(128, 255));
        endcase
      end
      2:       rdx = ird_pkg::RadixWidth'($urandom_range(0, 1));
      default: rdx = ird_pkg::RadixWidth'($urandom_range(17, 31));
    endcase
  endfunction

  function automatic logic [ird_pkg::ValueWidth-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(1, 40);
      2:       return -$urandom_range(1, 40);
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'hFFFF_FFFF;
      6:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    ird_pkg::digit_set_t set;
    logic [ird_pkg::RadixWidth-1:0] rdx;
    int p;
    int n;
    int count;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset the radix is 0, so this item is dropped
    send_value(32'd5);
    finish_phase();

    set = hex_digit_set();
    write_config(5'd10, set);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    finish_phase();

    write_config(5'd2, set);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h5555_5555);
    finish_phase();

    write_config(5'd16, set);
    send_value(32'hDEAD_BEEF);
    send_value(32'd255);
    send_value(32'hFFFF_FFFF);
    finish_phase();

    // rejected radices and digit sets
    convert_once(5'd1, set, 32'd77);
    convert_once(5'd17, set, 32'd77);
    convert_once(5'd31, set, 32'hAAAA_AAAA);
    set = hex_digit_set();
    set[3] = ird_pkg::CharMinus;
    convert_once(5'd10, set, 32'd12);
    set = hex_digit_set();
    set[9] = ird_pkg::CharPlus;
    convert_once(5'd10, set, 32'd12);
    set = hex_digit_set();
    set[0] = 8'h1F;
    convert_once(5'd10, set, 32'd12);
    set = hex_digit_set();
    set[5] = 8'h80;
    convert_once(5'd10, set, 32'd12);
    set = hex_digit_set();
    set[15] = set[0];
    convert_once(5'd16, set, 32'd12);

    // space and DEL are legal digits; junk in unused bytes is never looked at
    set = '0;
    set[0] = 8'h20;
    set[1] = 8'h7F;
    set[2] = 8'h61;
    set[3] = ird_pkg::CharMinus;
    set[4] = ird_pkg::CharPlus;
    set[6] = 8'hFF;
    set[7] = 8'h20;
    write_config(5'd3, set);
    send_value(-32'sd7);
    send_value(32'd100);
    finish_phase();

    for (p = 0; p < RandomPhases; p++) begin
      if (p == 0) rdx = 5'd2;
      else if (p == 1) rdx = 5'd16;
      else rdx = ird_pkg::RadixWidth'($urandom_range(2, 16));
      set = random_digit_set(rdx);
      count = 36;
      if (p % 4 == 3) begin
        spoil_digit_set(rdx, set);
        count = 6;
      end
      write_config(rdx, set);
      if (p == 0) hold_off_req = 1'b1;
      for (n = 0; n < count; n++) begin
        if (n == count / 2 && p % 2 == 0) wait_for_results();
        send_value(random_value());
      end
      finish_phase();
    end

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: integer_to_radix_digits_top.f
rtl/core/ird_pkg.sv
rtl/core/ird_check.sv
rtl/core/ird_div.sv
rtl/core/integer_to_radix_digits_top.sv
test/radix_text_checker.sv
test/tb_integer_to_radix_digits_top.sv
